### design/hpt_pkg.sv
// shared types and constants for the homogeneous point transform core
package hpt_pkg;

    localparam int DATA_W     = 32;
    localparam int QUO_W      = 32;
    localparam int COEF_W     = 64;
    localparam int NUM_REGS   = 8;
    localparam int CFG_ADDR_W = 4;
    localparam int NUM_COORD  = 3;

    // command codes
    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_DIR   = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1_XY  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1_ZW  = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW2_XY  = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW2_ZW  = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW3_XY  = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW3_ZW  = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANS_XY = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANS_ZW = 4'd7;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_bank_t;

    // per-coordinate side info that rides along the divider
    typedef struct packed {
        logic              fix;    // result settled before the divide
        logic [DATA_W-1:0] fval;   // settled result
        logic              fclip;  // settled result was clipped
        logic              neg;    // quotient sign
        logic              wz;     // point mode with zero w
    } coord_info_t;

endpackage

### design/homogeneous_point_transform_core.sv
// Pipeline: an accepted input beat passes the multiply, sum, divide setup,
// 32 divider stages and output register, in that order.
// Throughput: one beat per cycle; the whole pipeline stalls while the
// output register holds a beat that is not taken.
// Reset: synchronous active-low aresetn clears all stage valids and the
// matrix registers to zero.
module homogeneous_point_transform_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hpt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [hpt_pkg::COEF_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic signed [31:0]                 s_in_x,
    input  logic signed [31:0]                 s_in_y,
    input  logic signed [31:0]                 s_in_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [31:0]                 m_out_x,
    output logic signed [31:0]                 m_out_y,
    output logic signed [31:0]                 m_out_z,
    output logic                               m_w_zero,
    output logic                               m_saturated
);
    import hpt_pkg::*;

    localparam int SumW = 66 - FRAC_BITS;
    localparam int NumW = SumW + FRAC_BITS;

    coef_bank_t           coef_reg;
    logic                 adv;
    logic                 mac_valid;
    logic                 mac_cmd;
    logic [3:0][SumW-1:0] mac_sum;

    logic                 prep_vld_reg;
    logic [SumW-1:0]      prep_rem_reg  [NUM_COORD];
    logic [SumW-1:0]      prep_den_reg  [NUM_COORD];
    logic [31:0]          prep_low_reg  [NUM_COORD];
    coord_info_t          prep_info_reg [NUM_COORD];
    logic [SumW-1:0]      prep_rem_next [NUM_COORD];
    logic [SumW-1:0]      prep_den_next [NUM_COORD];
    logic [31:0]          prep_low_next [NUM_COORD];
    coord_info_t          prep_info_next[NUM_COORD];

    logic [NUM_COORD-1:0] div_valid;
    logic [31:0]          div_quo   [NUM_COORD];
    coord_info_t          div_info  [NUM_COORD];
    logic [31:0]          res_next  [NUM_COORD];
    logic [NUM_COORD-1:0] clip_next;

    logic                 m_valid_reg;
    logic [31:0]          res_reg   [NUM_COORD];
    logic                 wz_reg;
    logic                 sat_reg;

    // global pipeline advance
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    // matrix registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_valid && cfg_addr < CFG_ADDR_W'(NUM_REGS)) begin
            coef_reg[cfg_addr[2:0]] <= cfg_data;
        end
    end

    hpt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_cmd    (s_command),
        .in_x      (s_in_x),
        .in_y      (s_in_y),
        .in_z      (s_in_z),
        .coef      (coef_reg),
        .out_valid (mac_valid),
        .out_cmd   (mac_cmd),
        .out_sum   (mac_sum)
    );

    // divide setup: settle direction, zero w and overflow cases
    for (genvar c = 0; c < NUM_COORD; c++) begin : g_prep
        logic signed [SumW-1:0] s;
        logic signed [SumW-1:0] w;
        logic [SumW-1:0]        smag;
        logic [SumW-1:0]        wmag;
        logic [NumW-1:0]        num;
        logic [SumW-1:0]        nhi;
        logic                   in_range;
        logic                   ovf;

        assign s        = $signed(mac_sum[c]);
        assign w        = $signed(mac_sum[3]);
        assign smag     = s[SumW-1] ? SumW'(-s) : SumW'(s);
        assign wmag     = w[SumW-1] ? SumW'(-w) : SumW'(w);
        assign num      = {smag, {FRAC_BITS{1'b0}}};
        assign nhi      = SumW'(num[NumW-1:32]);
        assign in_range = (&s[SumW-1:31]) || !(|s[SumW-1:31]);
        assign ovf      = nhi >= wmag;

        always_comb begin
            prep_info_next[c]     = '0;
            prep_info_next[c].neg = s[SumW-1] ^ w[SumW-1];
            prep_rem_next[c]      = nhi;
            prep_den_next[c]      = wmag;
            prep_low_next[c]      = num[31:0];
            if (mac_cmd == CMD_DIR) begin
                prep_info_next[c].fix   = 1'b1;
                prep_info_next[c].fclip = !in_range;
                prep_info_next[c].fval  = in_range ? s[31:0]
                                        : (s[SumW-1] ? SAT_MIN : SAT_MAX);
            end else if (wmag == '0) begin
                prep_info_next[c].wz    = 1'b1;
                prep_info_next[c].fix   = 1'b1;
                prep_info_next[c].fclip = (s != '0);
                prep_info_next[c].fval  = (s == '0) ? '0
                                        : (s[SumW-1] ? SAT_MIN : SAT_MAX);
            end else if (ovf) begin
                prep_info_next[c].fix   = 1'b1;
                prep_info_next[c].fclip = 1'b1;
                prep_info_next[c].fval  = prep_info_next[c].neg ? SAT_MIN : SAT_MAX;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                prep_rem_reg[c]  <= prep_rem_next[c];
                prep_den_reg[c]  <= prep_den_next[c];
                prep_low_reg[c]  <= prep_low_next[c];
                prep_info_reg[c] <= prep_info_next[c];
            end
        end

        hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (prep_vld_reg),
            .in_rem    (prep_rem_reg[c]),
            .in_den    (prep_den_reg[c]),
            .in_low    (prep_low_reg[c]),
            .in_info   (prep_info_reg[c]),
            .out_valid (div_valid[c]),
            .out_quo   (div_quo[c]),
            .out_info  (div_info[c])
        );

        // sign and saturate the quotient
        always_comb begin
            if (div_info[c].fix) begin
                res_next[c]  = div_info[c].fval;
                clip_next[c] = div_info[c].fclip;
            end else if (div_info[c].neg) begin
                clip_next[c] = div_quo[c] > SAT_MIN;
                res_next[c]  = clip_next[c] ? SAT_MIN : 32'(32'd0 - div_quo[c]);
            end else begin
                clip_next[c] = div_quo[c][31];
                res_next[c]  = clip_next[c] ? SAT_MAX : div_quo[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (adv) begin
            prep_vld_reg <= mac_valid;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && div_valid[0]) begin
            res_reg <= res_next;
            wz_reg  <= div_info[0].wz;
            sat_reg <= |clip_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_x     = $signed(res_reg[0]);
    assign m_out_y     = $signed(res_reg[1]);
    assign m_out_z     = $signed(res_reg[2]);
    assign m_w_zero    = wz_reg;
    assign m_saturated = sat_reg;

    // an accepted beat reaches the sum stage once the pipe next advances
    a_accept_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 adv |=> mac_valid)
        else $error("accepted beat lost in multiply stage");

    // zero w without clipping only when every sum was zero
    a_wz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_w_zero && !m_saturated |->
        m_out_x == 32'sd0 && m_out_y == 32'sd0 && m_out_z == 32'sd0)
        else $error("zero w result not cleared");

    // a stall freezes the output beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> m_valid && $stable(m_out_x) && $stable(m_saturated))
        else $error("output changed during stall");

    // the three dividers stay in lockstep
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid[0] == div_valid[1] && div_valid[1] == div_valid[2])
        else $error("divider lanes out of step");

endmodule

### design/hpt_mac.sv
// multiply stage and summing stage of the matrix-vector product
module hpt_mac #(
    parameter int FRAC_BITS = 16,
    localparam int SumW     = 66 - FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic                           in_cmd,
    input  logic signed [31:0]             in_x,
    input  logic signed [31:0]             in_y,
    input  logic signed [31:0]             in_z,
    input  hpt_pkg::coef_bank_t            coef,
    output logic                           out_valid,
    output logic                           out_cmd,
    output logic [3:0][SumW-1:0]           out_sum
);
    import hpt_pkg::*;

    logic signed [63:0] prod_reg [3][4];
    logic signed [63:0] prod_next [3][4];
    logic               cmd1_reg;
    logic               vld1_reg;
    logic [3:0][SumW-1:0] sum_reg;
    logic [3:0][SumW-1:0] sum_next;
    logic               cmd2_reg;
    logic               vld2_reg;
    logic signed [31:0] vin [3];

    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;

    // twelve coordinate by coefficient products
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            localparam int Idx = r * 2 + c / 2;
            logic signed [31:0] cf;
            assign cf = $signed(coef[Idx][(c % 2) * 32 +: 32]);
            assign prod_next[r][c] = vin[r] * cf;
        end
    end

    // floor-shifted products summed, translation added for points
    for (genvar c = 0; c < 4; c++) begin : g_sum
        localparam int TIdx = 6 + c / 2;
        logic signed [31:0] tr;
        logic signed [SumW-1:0] trans;
        assign tr    = $signed(coef[TIdx][(c % 2) * 32 +: 32]);
        assign trans = (cmd1_reg == CMD_POINT) ? SumW'(tr) : '0;
        assign sum_next[c] = SumW'(prod_reg[0][c] >>> FRAC_BITS)
                           + SumW'(prod_reg[1][c] >>> FRAC_BITS)
                           + SumW'(prod_reg[2][c] >>> FRAC_BITS)
                           + trans;
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            cmd1_reg <= in_cmd;
            sum_reg  <= sum_next;
            cmd2_reg <= cmd1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign out_cmd   = cmd2_reg;
    assign out_sum   = sum_reg;

endmodule

### design/hpt_div.sv
// pipelined restoring divider, one quotient bit per stage
module hpt_div #(
    parameter int FRAC_BITS = 16,
    localparam int SumW     = 66 - FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [SumW-1:0]       in_rem,
    input  logic [SumW-1:0]       in_den,
    input  logic [31:0]           in_low,
    input  hpt_pkg::coord_info_t  in_info,
    output logic                  out_valid,
    output logic [31:0]           out_quo,
    output hpt_pkg::coord_info_t  out_info
);
    import hpt_pkg::*;

    logic [SumW-1:0]   rem_reg  [QUO_W];
    logic [SumW-1:0]   den_reg  [QUO_W];
    logic [QUO_W-1:0]  low_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    coord_info_t       info_reg [QUO_W];
    logic [QUO_W-1:0]  vld_reg;

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [SumW-1:0]  rem_prev;
        logic [SumW-1:0]  den_prev;
        logic [QUO_W-1:0] low_prev;
        logic [QUO_W-1:0] quo_prev;
        coord_info_t      info_prev;
        logic             vld_prev;
        logic [SumW:0]    trial;
        logic             ge;
        logic [SumW-1:0]  rem_next;

        if (i == 0) begin : g_first
            assign rem_prev  = in_rem;
            assign den_prev  = in_den;
            assign low_prev  = in_low;
            assign quo_prev  = '0;
            assign info_prev = in_info;
            assign vld_prev  = in_valid;
        end else begin : g_next
            assign rem_prev  = rem_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign low_prev  = low_reg[i-1];
            assign quo_prev  = quo_reg[i-1];
            assign info_prev = info_reg[i-1];
            assign vld_prev  = vld_reg[i-1];
        end

        // shift in the next dividend bit and try the subtract
        assign trial    = {rem_prev, low_prev[QUO_W-1]};
        assign ge       = trial >= {1'b0, den_prev};
        assign rem_next = ge ? SumW'(trial - {1'b0, den_prev}) : SumW'(trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (adv) begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_prev;
                low_reg[i]  <= {low_prev[QUO_W-2:0], 1'b0};
                quo_reg[i]  <= {quo_prev[QUO_W-2:0], ge};
                info_reg[i] <= info_prev;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_info  = info_reg[QUO_W-1];

endmodule
